// File: rtl/dsp_adpcm_frame_decoder_core_defines.svh
// Assertion macros for the ADPCM frame decoder checker.
`ifndef DSP_ADPCM_FRAME_DECODER_CORE_DEFINES_SVH
`define DSP_ADPCM_FRAME_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define DAFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dafd assertion failed");

// Next-cycle implication, masked during reset.
`define DAFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dafd assertion failed");

// Next-cycle implication, live through reset.
`define DAFD_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dafd reset assertion failed");

`endif

// File: rtl/dafd_pkg.sv
// Shared types, constants and coefficient ROM for the ADPCM frame decoder.
package dafd_pkg;

  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned CH_CMP_W  = 5;
  localparam int unsigned FRAC_BITS = 11;

  localparam logic signed [15:0] SAT_MAX = 16'sd32767;
  localparam logic signed [15:0] SAT_MIN = -16'sd32767;

  typedef logic signed [15:0] pcm_t;

  // one data word with its channel's header already resolved
  typedef struct packed {
    logic [2:0] channel;
    logic [3:0] scale;
    logic [3:0] pred;
    logic [7:0] data;
  } dafd_work_t;

  typedef struct packed {
    pcm_t c0;
    pcm_t c1;
  } coef_pair_t;

  typedef enum logic [1:0] {
    PH_HI = 2'b01,
    PH_LO = 2'b10
  } phase_t;

  function automatic coef_pair_t coef_rom(input logic [3:0] idx);
    coef_pair_t c;
    case (idx)
      4'd0:    c = '{c0: 16'sh0000, c1: 16'sh0000};
      4'd1:    c = '{c0: 16'sh0800, c1: 16'sh0000};
      4'd2:    c = '{c0: 16'sh0000, c1: 16'sh0800};
      4'd3:    c = '{c0: 16'sh0400, c1: 16'sh0400};
      4'd4:    c = '{c0: 16'sh1000, c1: -16'sh0800};
      4'd5:    c = '{c0: 16'sh0e00, c1: -16'sh0600};
      4'd6:    c = '{c0: 16'sh0c00, c1: -16'sh0400};
      4'd7:    c = '{c0: 16'sh1200, c1: -16'sh0a00};
      4'd8:    c = '{c0: 16'sh1068, c1: -16'sh08c8};
      4'd9:    c = '{c0: 16'sh12c0, c1: -16'sh08fc};
      4'd10:   c = '{c0: 16'sh1400, c1: -16'sh0c00};
      4'd11:   c = '{c0: 16'sh0800, c1: -16'sh0800};
      4'd12:   c = '{c0: 16'sh0400, c1: -16'sh0400};
      4'd13:   c = '{c0: -16'sh0400, c1: 16'sh0400};
      4'd14:   c = '{c0: -16'sh0400, c1: 16'sh0000};
      4'd15:   c = '{c0: -16'sh0800, c1: 16'sh0000};
      default: c = '{c0: 16'sh0000, c1: 16'sh0000};
    endcase
    return c;
  endfunction

endpackage

// File: rtl/dafd_front.sv
// Front end: accepts words, applies headers, forwards data words to the queue.
module dafd_front
  import dafd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_channel,
  input  logic        in_frame_start,
  input  logic [7:0]  in_data_byte,
  input  logic        q_full,
  output logic        q_push,
  output dafd_work_t  q_work
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [3:0]       scale_r [CHANNELS];
  logic [3:0]       pred_r  [CHANNELS];
  logic [IDX_W-1:0] idx;
  logic             accept;
  logic             ch_ok;

  assign idx      = IDX_W'(in_channel);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign ch_ok    = CH_CMP_W'(in_channel) < CH_CMP_W'(CHANNELS);
  assign q_push   = accept && ch_ok && !in_frame_start;

  assign q_work.channel = in_channel;
  assign q_work.scale   = scale_r[idx];
  assign q_work.pred    = pred_r[idx];
  assign q_work.data    = in_data_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        scale_r[i] <= '0;
        pred_r[i]  <= '0;
      end
    end else if (accept && ch_ok && in_frame_start) begin
      scale_r[idx] <= in_data_byte[7:4];
      pred_r[idx]  <= in_data_byte[3:0];
    end
  end

endmodule

// File: rtl/dafd_queue.sv
// Short FIFO of resolved data words between front and back.
module dafd_queue
  import dafd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  dafd_work_t push_work,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output dafd_work_t head_work
);

  dafd_work_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full      = count_r == (Q_PTR_W + 1)'(Q_DEPTH);
  assign valid     = count_r != '0;
  assign head_work = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/dafd_back.sv
// Back end: decodes two nibbles per data word against per-channel history.
module dafd_back
  import dafd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  dafd_work_t  q_work,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_channel,
  output logic signed [15:0] out_sample,
  output logic        out_last
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  pcm_t             h1_r [CHANNELS];
  pcm_t             h2_r [CHANNELS];
  phase_t           phase_r;
  logic             out_valid_r;
  logic [2:0]       out_channel_r;
  pcm_t             out_sample_r;
  logic             out_last_r;

  logic [IDX_W-1:0] idx;
  logic             fire;
  logic             second;
  logic [3:0]       nib;
  coef_pair_t       coef;
  pcm_t             h1;
  pcm_t             h2;
  logic signed [33:0] nib_ext;
  logic signed [33:0] step_term;
  logic signed [31:0] m1;
  logic signed [31:0] m2;
  logic signed [33:0] acc;
  logic signed [33:0] shifted;
  pcm_t             sample;

  assign idx    = IDX_W'(q_work.channel);
  assign fire   = q_valid && (!out_valid_r || out_ready);
  assign second = (phase_r == PH_LO);
  assign q_pop  = fire && second;

  assign nib  = second ? q_work.data[3:0] : q_work.data[7:4];
  assign coef = coef_rom(q_work.pred);
  assign h1   = h1_r[idx];
  assign h2   = h2_r[idx];

  always_comb begin
    nib_ext = 34'(signed'(nib));
    // scale 15 wraps to -32768 in 16-bit delta
    if (q_work.scale == 4'd15) begin
      step_term = -(nib_ext <<< 15);
    end else begin
      step_term = nib_ext <<< q_work.scale;
    end
    m1      = h1 * coef.c0;
    m2      = h2 * coef.c1;
    acc     = (step_term <<< FRAC_BITS) + 34'(m1) + 34'(m2);
    shifted = acc >>> FRAC_BITS;
    if (shifted > 34'sd32767) begin
      sample = SAT_MAX;
    end else if (shifted < -34'sd32767) begin
      sample = SAT_MIN;
    end else begin
      sample = shifted[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        h1_r[i] <= '0;
        h2_r[i] <= '0;
      end
    end else if (fire) begin
      h1_r[idx] <= sample;
      h2_r[idx] <= h1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HI;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        case (phase_r)
          PH_HI:   phase_r <= PH_LO;
          PH_LO:   phase_r <= PH_HI;
          default: phase_r <= PH_HI;
        endcase
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_channel_r <= q_work.channel;
      out_sample_r  <= sample;
      out_last_r    <= second;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_sample  = out_sample_r;
  assign out_last    = out_last_r;

endmodule

// File: rtl/dsp_adpcm_frame_decoder_core.sv
// Top level of the multichannel 4-bit ADPCM frame decoder.
//
//   Port group | Direction | Handshake          | Word
//   in_        | input     | in_valid/in_ready   | channel, frame_start, data_byte
//   out_       | output    | out_valid/out_ready | channel, sample, last
//
// A header word updates its channel's scale and predictor.
// A data word is decoded in the back end one nibble at a time: each sample
// goes through the shared multiply-accumulate and feeds the channel history.
// Reset clears scale, predictor and both history words of every channel.
// A two-word queue lets the front keep taking words while the output stalls, until it is full.
module dsp_adpcm_frame_decoder_core
  import dafd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_channel,
  input  logic        in_frame_start,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_channel,
  output logic signed [15:0] out_sample,
  output logic        out_last
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  dafd_work_t push_work;
  dafd_work_t head_work;

  dafd_front #(.CHANNELS(CHANNELS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_channel     (in_channel),
    .in_frame_start (in_frame_start),
    .in_data_byte   (in_data_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_work         (push_work)
  );

  dafd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_work (push_work),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_work (head_work)
  );

  dafd_back #(.CHANNELS(CHANNELS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_work      (head_work),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .out_sample  (out_sample),
    .out_last    (out_last)
  );

endmodule

// File: rtl/dafd_checker.sv
// Port-level checker for the ADPCM frame decoder, bound to the top level.
`include "dsp_adpcm_frame_decoder_core_defines.svh"

module dafd_checker
  import dafd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_channel,
  input logic        in_frame_start,
  input logic [7:0]  in_data_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_channel,
  input logic signed [15:0] out_sample,
  input logic        out_last
);

  // stalled word holds
  `DAFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(out_channel) && $stable(out_last))

  // saturation never yields the most negative code
  `DAFD_ASSERT_NOW(a_no_min, out_valid, out_sample != 16'sh8000)

  // second nibble of a word follows right after the first is taken
  `DAFD_ASSERT_NEXT(a_pair, out_valid && out_ready && !out_last, out_valid && out_last && (out_channel == $past(out_channel)))

  `DAFD_ASSERT_NOW(a_chan_range, out_valid, CH_CMP_W'(out_channel) < CH_CMP_W'(CHANNELS))

  `DAFD_ASSERT_RST(a_reset_idle, !rst_n, !out_valid)

endmodule

bind dsp_adpcm_frame_decoder_core dafd_checker #(.CHANNELS(CHANNELS)) u_dafd_checker (.*);

// File: dv/dafd_sample_checker.sv
// Checker for the ADPCM frame decoder: tracks channel state, predicts samples, compares output.
`timescale 1ns / 1ps

module dafd_sample_checker
  import dafd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_channel,
  input  logic              in_frame_start,
  input  logic [7:0]        in_data_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        out_channel,
  input  logic signed [15:0] out_sample,
  input  logic              out_last,
  output int                fail_count,
  output int                words_seen,
  output int                headers_seen,
  output int                samples_seen,
  output int                samples_pending
);

  localparam logic HEADER_WORD = 1'b1;

  // predictor coefficient pairs, indexed by the header's low nibble
  localparam int COEF_A [16] = '{
    0, 2048, 0, 1024, 4096, 3584, 3072, 4608,
    4200, 4800, 5120, 2048, 1024, -1024, -1024, -2048
  };
  localparam int COEF_B [16] = '{
    0, 0, 2048, 1024, -2048, -1536, -1024, -2560,
    -2248, -2300, -3072, -2048, -1024, 1024, 0, 0
  };

  typedef struct packed {
    logic [2:0] channel;
    pcm_t       sample;
    logic       last;
  } pcm_word_t;

  pcm_t       hist1   [CHANNELS];
  pcm_t       hist2   [CHANNELS];
  logic [3:0] scale_r [CHANNELS];
  logic [3:0] pred_r  [CHANNELS];

  pcm_word_t expected_samples [$];
  int fails;
  int words;
  int headers;
  int samples;

  // one nibble through the predictor; advances the channel history
  function automatic pcm_t adpcm_decode(int ch, logic [3:0] nib);
    longint step;
    longint acc;
    longint res;
    int     pi;
    pi   = int'(pred_r[ch]);
    step = (scale_r[ch] == 4'd15) ? -longint'(32768) : (longint'(1) << scale_r[ch]);
    acc  = step * longint'($signed(nib)) * 2048
         + longint'(hist1[ch]) * COEF_A[pi]
         + longint'(hist2[ch]) * COEF_B[pi];
    res  = acc >>> FRAC_BITS;  // floor
    if (res > longint'(SAT_MAX)) res = longint'(SAT_MAX);
    else if (res < longint'(SAT_MIN)) res = longint'(SAT_MIN);
    hist2[ch] = hist1[ch];
    hist1[ch] = pcm_t'(res);
    return pcm_t'(res);
  endfunction

  always @(posedge clk) begin
    pcm_word_t got;
    pcm_word_t want;
    pcm_word_t next_word;
    int        ch;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hist1[i]   = '0;
        hist2[i]   = '0;
        scale_r[i] = '0;
        pred_r[i]  = '0;
      end
      expected_samples.delete();
      fails   = 0;
      words   = 0;
      headers = 0;
      samples = 0;
    end else begin
      if (in_valid && in_ready) begin
        ch = int'(in_channel);
        words++;
        if (ch < CHANNELS) begin
          if (in_frame_start == HEADER_WORD) begin
            headers++;
            scale_r[ch] = in_data_byte[7:4];
            pred_r[ch]  = in_data_byte[3:0];
          end else begin
            next_word = '{in_channel, adpcm_decode(ch, in_data_byte[7:4]), 1'b0};
            expected_samples.insert(expected_samples.size(), next_word);
            next_word = '{in_channel, adpcm_decode(ch, in_data_byte[3:0]), 1'b1};
            expected_samples.insert(expected_samples.size(), next_word);
          end
        end
      end
      if (out_valid && out_ready) begin
        got = '{out_channel, out_sample, out_last};
        samples++;
        if (expected_samples.size() == 0) begin
          fails++;
          $display("%0t: unexpected sample: expected none, got ch %0d sample %0d last %0b",
                   $time, got.channel, got.sample, got.last);
        end else begin
          want = expected_samples.pop_front();
          if (got.channel != want.channel || got.sample != want.sample ||
              got.last != want.last) begin
            fails++;
            $display("%0t: sample error: expected ch %0d sample %0d last %0b,",
                     $time, want.channel, want.sample, want.last,
                     " got ch %0d sample %0d last %0b",
                     got.channel, got.sample, got.last);
          end
        end
      end
    end
    fail_count      <= fails;
    words_seen      <= words;
    headers_seen    <= headers;
    samples_seen    <= samples;
    samples_pending <= expected_samples.size();
  end

endmodule

// File: dv/dsp_adpcm_frame_decoder_core_test.sv
// Testbench top for the ADPCM frame decoder: clock, reset, word stimulus, output stalls, verdict.
`timescale 1ns / 1ps

module dsp_adpcm_frame_decoder_core_test;
  import dafd_pkg::*;

  localparam int   CHANNELS     = 8;
  localparam int   PHASE_WORDS  = 510;
  localparam int   FRAME_WORDS  = 9;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   STALL_LIMIT  = 4000;
  localparam int   DRAIN_CYCLES = 20;
  localparam logic HEADER_WORD  = 1'b1;
  localparam logic DATA_WORD    = 1'b0;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [2:0]  in_channel     = '0;
  logic        in_frame_start = 1'b0;
  logic [7:0]  in_data_byte   = '0;
  logic        out_ready      = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [2:0]  out_channel;
  logic signed [15:0] out_sample;
  logic        out_last;

  int fail_count;
  int words_seen;
  int headers_seen;
  int samples_seen;
  int samples_pending;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_trigger  = 1'b0;
  logic hold_seen;
  int   hold_left;
  int   stall_cycles;
  int   frame_pos [CHANNELS];

  always #2 clk = ~clk;

  dsp_adpcm_frame_decoder_core #(
    .CHANNELS(CHANNELS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_channel     (in_channel),
    .in_frame_start (in_frame_start),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_sample     (out_sample),
    .out_last       (out_last)
  );

  dafd_sample_checker #(
    .CHANNELS(CHANNELS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_frame_start  (in_frame_start),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel     (out_channel),
    .out_sample      (out_sample),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .words_seen      (words_seen),
    .headers_seen    (headers_seen),
    .samples_seen    (samples_seen),
    .samples_pending (samples_pending)
  );

  // receiver: random back-pressure, plus a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, giving up", $time, STALL_LIMIT);
        $display("dsp_adpcm_frame_decoder_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [2:0] ch, input logic fs, input logic [7:0] byte_val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_channel     <= ch;
    in_frame_start <= fs;
    in_data_byte   <= byte_val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // mostly well-formed interleaved frames, some noise and cut-short frames
  task automatic send_stream_word();
    int unsigned ch;
    int unsigned roll;
    logic [3:0]  scale;
    ch   = $urandom_range(0, CHANNELS - 1);
    roll = $urandom_range(0, 99);
    if (roll < 7) begin
      send_word(3'(ch), 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end else begin
      if (roll < 10) frame_pos[ch] = 0;
      if (frame_pos[ch] == 0) begin
        // keep most scales low so samples do not all saturate
        scale = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 11))
                                           : 4'($urandom_range(12, 15));
        send_word(3'(ch), HEADER_WORD, {scale, 4'($urandom_range(0, 15))});
      end else begin
        send_word(3'(ch), DATA_WORD, 8'($urandom_range(0, 255)));
      end
      frame_pos[ch] = (frame_pos[ch] + 1) % FRAME_WORDS;
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    if (with_hold) hold_trigger <= ~hold_trigger;
    repeat (PHASE_WORDS) send_stream_word();
  endtask

  initial begin
    for (int i = 0; i < CHANNELS; i++) frame_pos[i] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 38;
    recv_idle_pct <= 48;
    // data before any header decodes with scale 0, predictor 0
    send_word(3'd0, DATA_WORD, 8'h7F);
    send_word(3'd0, DATA_WORD, 8'h80);
    send_word(3'd7, DATA_WORD, 8'h00);
    // scale 15 gives a negative step, both rails
    send_word(3'd1, HEADER_WORD, 8'hF0);
    send_word(3'd1, DATA_WORD, 8'h18);
    send_word(3'd1, DATA_WORD, 8'hF7);
    send_word(3'd2, HEADER_WORD, 8'hC9);
    send_word(3'd2, DATA_WORD, 8'h77);
    send_word(3'd2, DATA_WORD, 8'h77);
    send_word(3'd2, DATA_WORD, 8'h88);
    send_word(3'd3, HEADER_WORD, 8'hFF);
    send_word(3'd3, DATA_WORD, 8'hF1);
    send_word(3'd7, HEADER_WORD, 8'h00);
    send_word(3'd7, DATA_WORD, 8'hFF);
    // negative history with fractional coefficients exercises floor rounding
    send_word(3'd4, HEADER_WORD, 8'h38);
    send_word(3'd4, DATA_WORD, 8'h9F);
    send_word(3'd4, DATA_WORD, 8'h1E);
    send_word(3'd5, HEADER_WORD, 8'h2D);
    send_word(3'd5, DATA_WORD, 8'hA5);
    send_word(3'd6, HEADER_WORD, 8'hB4);
    send_word(3'd6, DATA_WORD, 8'h7F);
    send_word(3'd6, DATA_WORD, 8'h80);
    // history carries on past the earlier words of channel 0
    send_word(3'd0, DATA_WORD, 8'h5A);

    run_phase(38, 48, 1'b0);
    run_phase(48, 38, 1'b1);
    run_phase(0, 0, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words (%0d headers) on %0d channels, %0d samples compared",
             words_seen, headers_seen, CHANNELS, samples_seen);
    $display("idle mixes 38/48, 48/38 and none, with one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("dsp_adpcm_frame_decoder_core: match");
    end else begin
      $display("dsp_adpcm_frame_decoder_core: mismatch");
    end
    $finish;
  end

endmodule
